FILE: design/spq_pkg.sv
`timescale 1ns / 1ps
// spq_pkg: shared types and codes of the sorted priority queue
// no dependencies; used by spq_cell and sorted_priority_queue
package spq_pkg;

    localparam int PRI_BITS = 2;
    localparam int PAY_PORT_BITS = 16;
    localparam int STATUS_BITS = 2;
    localparam int OCC_BITS = 4;

    typedef logic [PRI_BITS-1:0] pri_t;
    typedef logic [STATUS_BITS-1:0] status_t;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    // result status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    // where a cell takes its next entry from
    localparam logic [1:0] SRC_HOLD  = 2'd0;
    localparam logic [1:0] SRC_NEW   = 2'd1;
    localparam logic [1:0] SRC_LEFT  = 2'd2;
    localparam logic [1:0] SRC_RIGHT = 2'd3;

    typedef struct packed {
        logic [1:0] src;
    } cell_ctrl_t;

endpackage

FILE: design/sorted_priority_queue.sv
`timescale 1ns / 1ps
// sorted_priority_queue: row of DEPTH slot cells kept sorted by priority
// depends on spq_pkg and spq_cell
//
// One request per clock: every cell compares its priority with the incoming
// one in the same cycle and either holds, loads the new entry, or takes its
// neighbor's entry; the whole row updates together on an insert or a removal.
// busy is always low; the result appears on the cycle after start with done
// high for exactly that one cycle and must be captured then, since the
// receiver cannot stall. occupancy is valid while done is high. Equal
// priorities leave in arrival order; slot 0 is the head.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH        = 8,
    parameter int PAYLOAD_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     req_type,
    input  logic [PAY_PORT_BITS-1:0] entry_payload,
    input  pri_t                     entry_priority,
    output logic                     done,
    output status_t                  status,
    output logic [PAY_PORT_BITS-1:0] head_payload,
    output pri_t                     head_priority,
    output logic [OCC_BITS-1:0]      occupancy
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [PAYLOAD_BITS-1:0] cell_pay [DEPTH];
    pri_t                    cell_pri [DEPTH];
    logic [DEPTH-1:0]        cell_vld;
    logic [DEPTH-1:0]        cell_keep;
    cell_ctrl_t              cell_ctrl [DEPTH];

    logic [PAYLOAD_BITS-1:0] new_pay;
    logic                    accept;
    logic                    full;
    logic                    empty;
    logic                    do_insert;
    logic                    do_remove;

    logic                     done_reg;
    status_t                  status_reg;
    status_t                  status_next;
    logic [PAY_PORT_BITS-1:0] head_payload_reg;
    logic [PAY_PORT_BITS-1:0] head_payload_next;
    pri_t                     head_priority_reg;
    pri_t                     head_priority_next;
    logic [CNT_BITS-1:0]      count_reg;
    logic [CNT_BITS-1:0]      count_next;

    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign new_pay   = PAYLOAD_BITS'(entry_payload);
    assign full      = cell_vld[DEPTH-1];
    assign empty     = !cell_vld[0];
    assign do_insert = accept && (req_type == REQ_INSERT) && !full;
    assign do_remove = accept && (req_type == REQ_REMOVE) && !empty;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic                    l_vld;
            pri_t                    l_pri;
            logic [PAYLOAD_BITS-1:0] l_pay;
            logic                    r_vld;
            pri_t                    r_pri;
            logic [PAYLOAD_BITS-1:0] r_pay;
            logic                    left_keep;

            if (gi == 0)
            begin : g_head
                assign l_vld     = 1'b0;
                assign l_pri     = '0;
                assign l_pay     = '0;
                assign left_keep = 1'b1;
            end
            else
            begin : g_body
                assign l_vld     = cell_vld[gi-1];
                assign l_pri     = cell_pri[gi-1];
                assign l_pay     = cell_pay[gi-1];
                assign left_keep = cell_keep[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign r_vld = 1'b0;
                assign r_pri = '0;
                assign r_pay = '0;
            end
            else
            begin : g_inner
                assign r_vld = cell_vld[gi+1];
                assign r_pri = cell_pri[gi+1];
                assign r_pay = cell_pay[gi+1];
            end

            // insertion point is the first cell that does not keep its entry
            always_comb
            begin
                if (do_insert)
                begin
                    if (cell_keep[gi])
                        cell_ctrl[gi].src = SRC_HOLD;
                    else if (left_keep)
                        cell_ctrl[gi].src = SRC_NEW;
                    else
                        cell_ctrl[gi].src = SRC_LEFT;
                end
                else if (do_remove)
                begin
                    cell_ctrl[gi].src = SRC_RIGHT;
                end
                else
                begin
                    cell_ctrl[gi].src = SRC_HOLD;
                end
            end

            spq_cell #(
                .PAYLOAD_BITS (PAYLOAD_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl[gi]),
                .new_pri   (entry_priority),
                .new_pay   (new_pay),
                .left_vld  (l_vld),
                .left_pri  (l_pri),
                .left_pay  (l_pay),
                .right_vld (r_vld),
                .right_pri (r_pri),
                .right_pay (r_pay),
                .vld       (cell_vld[gi]),
                .pri       (cell_pri[gi]),
                .pay       (cell_pay[gi]),
                .keep      (cell_keep[gi])
            );
        end
    endgenerate

    always_comb
    begin
        status_next        = ST_OK;
        head_payload_next  = '0;
        head_priority_next = '0;
        count_next         = count_reg;
        if (accept)
        begin
            case (req_type)
                REQ_INSERT:
                begin
                    if (full)
                        status_next = ST_FULL;
                    else
                        count_next = count_reg + CNT_BITS'(1);
                end
                REQ_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        head_payload_next  = PAY_PORT_BITS'(cell_pay[0]);
                        head_priority_next = cell_pri[0];
                        count_next         = count_reg - CNT_BITS'(1);
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg  <= accept;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg        <= status_next;
        head_payload_reg  <= head_payload_next;
        head_priority_reg <= head_priority_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign head_payload  = head_payload_reg;
    assign head_priority = head_priority_reg;
    assign occupancy     = OCC_BITS'(count_reg);

    // live entries always sit in a contiguous run from the head
    a_vld_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_vld & (cell_vld + DEPTH'(1))) == '0))
        else $error("valid cells are not contiguous from the head");

    // occupancy counter tracks the live cells
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == CNT_BITS'($countones(cell_vld))))
        else $error("entry count disagrees with valid cells");

    // a rejected transaction leaves the row untouched
    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((req_type == REQ_INSERT && full) || (req_type == REQ_REMOVE && empty)))
        |=> $stable(cell_vld))
        else $error("rejected transaction changed the queue");

    // failed transactions report no head entry
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (head_payload == '0 && head_priority == '0))
        else $error("failed transaction returned a head entry");

    // head never outranked by the second slot
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_vld[1] |-> (cell_pri[0] >= cell_pri[1])))
        else $error("head is not the highest priority entry");

endmodule

FILE: design/spq_cell.sv
`timescale 1ns / 1ps
// spq_cell: one slot of the sorted queue, holds an entry and a valid bit
// depends on spq_pkg
module spq_cell
    import spq_pkg::*;
#(
    parameter int PAYLOAD_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctrl_t              ctrl,
    input  pri_t                    new_pri,
    input  logic [PAYLOAD_BITS-1:0] new_pay,
    input  logic                    left_vld,
    input  pri_t                    left_pri,
    input  logic [PAYLOAD_BITS-1:0] left_pay,
    input  logic                    right_vld,
    input  pri_t                    right_pri,
    input  logic [PAYLOAD_BITS-1:0] right_pay,
    output logic                    vld,
    output pri_t                    pri,
    output logic [PAYLOAD_BITS-1:0] pay,
    output logic                    keep
);

    logic                    vld_reg;
    logic                    vld_next;
    pri_t                    pri_reg;
    pri_t                    pri_next;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [PAYLOAD_BITS-1:0] pay_next;

    // entry stays put on insert when it is at least as urgent as the new one
    assign keep = vld_reg && (pri_reg >= new_pri);

    always_comb
    begin
        vld_next = vld_reg;
        pri_next = pri_reg;
        pay_next = pay_reg;
        case (ctrl.src)
            SRC_NEW:
            begin
                vld_next = 1'b1;
                pri_next = new_pri;
                pay_next = new_pay;
            end
            SRC_LEFT:
            begin
                vld_next = left_vld;
                pri_next = left_pri;
                pay_next = left_pay;
            end
            SRC_RIGHT:
            begin
                vld_next = right_vld;
                pri_next = right_pri;
                pay_next = right_pay;
            end
            default:
            begin
                vld_next = vld_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pri_reg <= pri_next;
        pay_reg <= pay_next;
    end

    assign vld = vld_reg;
    assign pri = pri_reg;
    assign pay = pay_reg;

endmodule

FILE: bench/sorted_priority_queue_test.sv
`timescale 1ns / 1ps
// sorted_priority_queue_test: self-checking bench for the sorted priority queue
// depends on spq_pkg and sorted_priority_queue; a directed table, then random traffic
module sorted_priority_queue_test;
    import spq_pkg::*;

    localparam int QUEUE_DEPTH = 8;
    localparam int SCRIPT_ROWS = 22;
    localparam int ITEMS_PER_PHASE = 650;

    typedef struct packed {
        status_t                  st;
        logic [PAY_PORT_BITS-1:0] tag;
        pri_t                     rank;
        logic [OCC_BITS-1:0]      occ;
    } outcome_t;

    typedef struct packed {
        logic                     req;
        logic [PAY_PORT_BITS-1:0] tag;
        pri_t                     rank;
        logic                     typed;
        outcome_t                 want;
    } script_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     req_type = REQ_INSERT;
    logic [PAY_PORT_BITS-1:0] entry_payload = '0;
    pri_t                     entry_priority = '0;
    logic                     busy;
    logic                     done;
    status_t                  status;
    logic [PAY_PORT_BITS-1:0] head_payload;
    pri_t                     head_priority;
    logic [OCC_BITS-1:0]      occupancy;

    // row-supplied expectation, travels with the transaction
    logic     typed_row = 1'b0;
    outcome_t typed_want = '0;

    // shadow copy of the queue contents
    logic [PAY_PORT_BITS-1:0] shadow_tag [QUEUE_DEPTH];
    pri_t                     shadow_rank [QUEUE_DEPTH];
    int unsigned              shadow_held = 0;

    outcome_t pending_outcomes [$];
    int       mismatch_count = 0;

    script_row_t script [0:SCRIPT_ROWS-1] = '{
        '{REQ_REMOVE, 16'h0000, 2'd0, 1'b1, '{ST_EMPTY, 16'h0000, 2'd0, 4'd0}},
        '{REQ_INSERT, 16'h0000, 2'd0, 1'b1, '{ST_OK,    16'h0000, 2'd0, 4'd1}},
        '{REQ_INSERT, 16'hFFFF, 2'd3, 1'b1, '{ST_OK,    16'h0000, 2'd0, 4'd2}},
        '{REQ_INSERT, 16'h1234, 2'd1, 1'b1, '{ST_OK,    16'h0000, 2'd0, 4'd3}},
        '{REQ_INSERT, 16'hAAAA, 2'd3, 1'b1, '{ST_OK,    16'h0000, 2'd0, 4'd4}},
        '{REQ_INSERT, 16'h5555, 2'd2, 1'b1, '{ST_OK,    16'h0000, 2'd0, 4'd5}},
        '{REQ_INSERT, 16'h0001, 2'd1, 1'b1, '{ST_OK,    16'h0000, 2'd0, 4'd6}},
        '{REQ_INSERT, 16'h8000, 2'd0, 1'b1, '{ST_OK,    16'h0000, 2'd0, 4'd7}},
        '{REQ_INSERT, 16'h7FFF, 2'd3, 1'b1, '{ST_OK,    16'h0000, 2'd0, 4'd8}},
        '{REQ_INSERT, 16'hFFFF, 2'd3, 1'b1, '{ST_FULL,  16'h0000, 2'd0, 4'd8}},
        '{REQ_INSERT, 16'h0000, 2'd0, 1'b1, '{ST_FULL,  16'h0000, 2'd0, 4'd8}},
        '{REQ_REMOVE, 16'hFFFF, 2'd3, 1'b1, '{ST_OK,    16'hFFFF, 2'd3, 4'd7}},
        '{REQ_REMOVE, 16'h0000, 2'd0, 1'b1, '{ST_OK,    16'hAAAA, 2'd3, 4'd6}},
        '{REQ_REMOVE, 16'hC3C3, 2'd1, 1'b0, '0},
        '{REQ_REMOVE, 16'h3C3C, 2'd2, 1'b0, '0},
        '{REQ_REMOVE, 16'h0000, 2'd0, 1'b0, '0},
        '{REQ_REMOVE, 16'hFFFF, 2'd3, 1'b0, '0},
        '{REQ_REMOVE, 16'h0F0F, 2'd0, 1'b0, '0},
        '{REQ_REMOVE, 16'hF0F0, 2'd1, 1'b0, '0},
        '{REQ_REMOVE, 16'hFFFF, 2'd3, 1'b1, '{ST_EMPTY, 16'h0000, 2'd0, 4'd0}},
        '{REQ_INSERT, 16'hBEEF, 2'd2, 1'b0, '0},
        '{REQ_REMOVE, 16'h0000, 2'd0, 1'b0, '0}
    };

    sorted_priority_queue #(
        .DEPTH        (QUEUE_DEPTH),
        .PAYLOAD_BITS (PAY_PORT_BITS)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .entry_payload  (entry_payload),
        .entry_priority (entry_priority),
        .done           (done),
        .status         (status),
        .head_payload   (head_payload),
        .head_priority  (head_priority),
        .occupancy      (occupancy)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // applies one request to the shadow queue and returns what the block should report
    function automatic outcome_t serve_request(input logic req,
                                               input logic [PAY_PORT_BITS-1:0] tag,
                                               input pri_t rank);
        outcome_t    res;
        int unsigned pos;
        res = '0;
        res.st = ST_OK;
        if (req == REQ_INSERT)
        begin
            if (shadow_held >= QUEUE_DEPTH)
                res.st = ST_FULL;
            else
            begin
                pos = shadow_held;
                // lower-priority entries slide back; ties stay ahead of the newcomer
                while (pos > 0 && shadow_rank[pos-1] < rank)
                begin
                    shadow_tag[pos]  = shadow_tag[pos-1];
                    shadow_rank[pos] = shadow_rank[pos-1];
                    pos--;
                end
                shadow_tag[pos]  = tag;
                shadow_rank[pos] = rank;
                shadow_held++;
            end
        end
        else
        begin
            if (shadow_held == 0)
                res.st = ST_EMPTY;
            else
            begin
                res.tag  = shadow_tag[0];
                res.rank = shadow_rank[0];
                for (int i = 0; i + 1 < shadow_held; i++)
                begin
                    shadow_tag[i]  = shadow_tag[i+1];
                    shadow_rank[i] = shadow_rank[i+1];
                end
                shadow_held--;
            end
        end
        res.occ = shadow_held[OCC_BITS-1:0];
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // result check first, then capture of a newly accepted transaction
    always @(posedge clk)
    begin
        outcome_t want;
        outcome_t predicted;
        if (rst_n)
        begin
            if (done === 1'b1)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: result with none expected, actual status %0h payload %0h",
                             $time, status, head_payload);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    compare_field("status", 32'(want.st), 32'(status));
                    compare_field("head_payload", 32'(want.tag), 32'(head_payload));
                    compare_field("head_priority", 32'(want.rank), 32'(head_priority));
                    compare_field("occupancy", 32'(want.occ), 32'(occupancy));
                end
            end
            if (start && busy === 1'b0)
            begin
                predicted = serve_request(req_type, entry_payload, entry_priority);
                pending_outcomes.push_back(typed_row ? typed_want : predicted);
            end
        end
    end

    task automatic issue_request(input logic req, input logic [PAY_PORT_BITS-1:0] tag,
                                 input pri_t rank, input logic typed, input outcome_t want);
        start          <= 1'b1;
        req_type       <= req;
        entry_payload  <= tag;
        entry_priority <= rank;
        typed_row      <= typed;
        typed_want     <= want;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    task automatic sender_gap(input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain_pending();
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int idle_pct [3];
        int sent;
        int insert_pct;
        int burst;
        int spins;
        idle_pct = '{13, 79, 0};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            issue_request(script[i].req, script[i].tag, script[i].rank,
                          script[i].typed, script[i].want);
            sender_gap(idle_pct[0]);
        end
        drain_pending();

        for (int phase = 0; phase < 3; phase++)
        begin
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                // bursts lean toward filling or draining so both full and empty get hit
                case ($urandom_range(0, 3))
                    0: insert_pct = 15;
                    1: insert_pct = 50;
                    2: insert_pct = 85;
                    default: insert_pct = 97;
                endcase
                burst = $urandom_range(4, 24);
                for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++)
                begin
                    issue_request(($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE,
                                  PAY_PORT_BITS'($urandom), pri_t'($urandom_range(0, 3)),
                                  1'b0, '0);
                    sender_gap(idle_pct[phase]);
                    sent++;
                end
            end
            drain_pending();
        end

        start <= 1'b0;
        spins = 0;
        while (pending_outcomes.size() != 0 && spins < 1000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (4) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_outcomes.size());
            mismatch_count += pending_outcomes.size();
        end

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
